// ----- src/masked_byte_pattern_scanner_macros.svh -----
// ----------------------------------------------------------------------------
// masked byte pattern scanner assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define MBPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define MBPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mbps_pkg.sv -----
// ----------------------------------------------------------------------------
// mbps_pkg
// types and constants shared by the masked byte pattern scanner
// ----------------------------------------------------------------------------
package mbps_pkg;

  // signature storage is fixed at sixteen bytes
  localparam int unsigned SIG_BYTES = 16;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_WILDCARD     = 3'd2,
    REG_LENGTH       = 3'd3,
    REG_SCAN_BASE    = 3'd4
  } cfg_reg_t;

  // one input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       span_end;
  } in_item_t;

  // one result
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] first_address;
    logic [CNT_W-1:0]  match_count;
  } out_item_t;

  // compare stage to tally stage
  typedef struct packed {
    logic             hit;
    logic             last;
    logic [CNT_W-1:0] offset;
  } hit_t;

endpackage

// ----- src/mbps_cell.sv -----
// ----------------------------------------------------------------------------
// mbps_cell
// one window byte: holds it, passes it on, compares the incoming byte
// ----------------------------------------------------------------------------
module mbps_cell
  import mbps_pkg::*;
(
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] byte_in,
  input  logic [7:0] ref_byte,
  input  logic       in_use,
  input  logic       wild,
  output logic [7:0] byte_out,
  output logic       match
);

  // byte register, moves one place per accepted request
  always_ff @(posedge clk) begin
    if (shift) begin
      byte_out <= byte_in;
    end
  end

  // compare on the byte this cell is about to hold
  assign match = !in_use || wild || (byte_in == ref_byte);

endmodule

// ----- src/mbps_tally.sv -----
// ----------------------------------------------------------------------------
// mbps_tally
// match counter, first match capture and result register
// ----------------------------------------------------------------------------
module mbps_tally
  import mbps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  hit_t              hit_in,
  input  logic [ADDR_W-1:0] scan_base,
  input  logic              out_ready,
  output logic              out_valid,
  output out_item_t         out_data
);

  logic             have_first;
  logic [CNT_W-1:0] first_offset;
  logic [CNT_W-1:0] match_total;

  logic             have_first_next;
  logic [CNT_W-1:0] first_offset_next;
  logic [CNT_W-1:0] match_total_next;

  // saturating count and first capture
  always_comb begin
    match_total_next = match_total;
    if (hit_in.hit && (match_total != {CNT_W{1'b1}})) begin
      match_total_next = match_total + CNT_W'(1);
    end
    have_first_next   = have_first || hit_in.hit;
    first_offset_next = have_first ? first_offset : hit_in.offset;
  end

  // accumulators, cleared after each span
  always_ff @(posedge clk) begin
    if (rst) begin
      have_first   <= 1'b0;
      first_offset <= '0;
      match_total  <= '0;
    end else if (take) begin
      if (hit_in.last) begin
        have_first   <= 1'b0;
        first_offset <= '0;
        match_total  <= '0;
      end else begin
        have_first   <= have_first_next;
        first_offset <= first_offset_next;
        match_total  <= match_total_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && hit_in.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && hit_in.last) begin
      out_data.found         <= have_first_next;
      out_data.first_address <= have_first_next
                                ? scan_base + {{(ADDR_W-CNT_W){1'b0}}, first_offset_next}
                                : '0;
      out_data.match_count   <= match_total_next;
    end
  end

endmodule

// ----- src/masked_byte_pattern_scanner.sv -----
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// wildcard byte signature search over a streamed memory span
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle, with no gaps needed between requests, while
// no span end request is stalled. Each byte shifts into a row of MAX_PATTERN
// window cells; every cell compares the byte it receives against its
// signature byte, and the hit is registered at the accepting edge. The
// following stage counts matches and keeps the first match offset. On the
// byte marked span_end the tally loads the result (found, first_address,
// match_count) when that request leaves the compare stage. The result
// register frees the input side, so the next span streams in while a result
// waits; only its span end request stalls until that result is taken. Write
// configuration only while no request is in flight.
module masked_byte_pattern_scanner
  import mbps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 16
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

`include "masked_byte_pattern_scanner_macros.svh"

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

  // configuration registers
  logic [63:0]          pattern_low;
  logic [63:0]          pattern_high;
  logic [SIG_BYTES-1:0] wildcard_bits;
  logic [LEN_W-1:0]     pattern_length;
  logic [ADDR_W-1:0]    scan_base;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      wildcard_bits  <= '0;
      pattern_length <= LEN_W'(1);
      scan_base      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        REG_WILDCARD:     wildcard_bits  <= cfg_data[SIG_BYTES-1:0];
        REG_LENGTH:       pattern_length <= cfg_data[LEN_W-1:0];
        REG_SCAN_BASE:    scan_base      <= cfg_data;
        default: ;
      endcase
    end
  end

  // length in use, clamped to the window
  logic [LEN_W-1:0] len;
  always_comb begin
    if (pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (pattern_length > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = pattern_length;
    end
  end

  logic [SIG_BYTES-1:0][7:0] sig_bytes;
  assign sig_bytes = {pattern_high, pattern_low};

  // handshake and stage control
  logic a_valid;
  hit_t a_req;
  logic out_free;
  logic a_take;
  logic in_take;

  assign out_free = !out_valid || out_ready;
  assign a_take   = a_valid && (!a_req.last || out_free);
  assign in_ready = !a_valid || a_take;
  assign in_take  = in_valid && in_ready;

  // window cell row, cell 0 holds the newest byte
  logic [7:0]             win [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_match;

  for (genvar pos = 0; pos < MAX_PATTERN; pos++) begin : g_cell
    logic [LEN_W-1:0] sig_idx;
    logic [7:0]       byte_in;
    logic             in_use;

    assign in_use  = LEN_W'(pos) < len;
    assign sig_idx = len - LEN_W'(1) - LEN_W'(pos);

    if (pos == 0) begin : g_head
      assign byte_in = in_data.data_byte;
    end else begin : g_link
      assign byte_in = win[pos-1];
    end

    mbps_cell u_cell (
      .clk      (clk),
      .shift    (in_take),
      .byte_in  (byte_in),
      .ref_byte (sig_bytes[sig_idx[3:0]]),
      .in_use   (in_use),
      .wild     (wildcard_bits[sig_idx[3:0]]),
      .byte_out (win[pos]),
      .match    (cell_match[pos])
    );
  end

  // bytes of the current span, saturating
  logic [CNT_W-1:0] bytes_seen;
  logic [CNT_W-1:0] bytes_seen_next;

  assign bytes_seen_next = (bytes_seen == {CNT_W{1'b1}}) ? bytes_seen
                                                         : bytes_seen + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
    end else if (in_take) begin
      bytes_seen <= in_data.span_end ? '0 : bytes_seen_next;
    end
  end

  // compare stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_take) begin
      a_valid <= 1'b1;
    end else if (a_take) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_req.hit    <= (bytes_seen_next >= CNT_W'(len)) && (&cell_match);
      a_req.last   <= in_data.span_end;
      a_req.offset <= bytes_seen_next - CNT_W'(len);
    end
  end

  // match tally and result register
  mbps_tally u_tally (
    .clk       (clk),
    .rst       (rst),
    .take      (a_take),
    .hit_in    (a_req),
    .scan_base (scan_base),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // checks
  `MBPS_ASSERT_NOW(a_stall_only_when_full, !in_ready, a_valid,
    "input stalled with empty compare stage")
  `MBPS_ASSERT_NEXT(a_last_held, a_valid && a_req.last && !out_free,
    a_valid && a_req.last, "blocked span end request lost")
  `MBPS_ASSERT_NOW(no_find_zero_addr, out_valid && !out_data.found,
    out_data.first_address == '0, "address set without a match")
  `MBPS_ASSERT_NOW(find_has_count, out_valid && out_data.found,
    out_data.match_count != '0, "match found with zero count")

endmodule
